// ===== rtl/core/lpgq_pkg.sv =====
// Shared constants, codes and types for the projection grid quantizer.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps

package lpgq_pkg;

   // Default sizes, handed down from the top level
   localparam int NUM_PROJ_DEF  = 8;
   localparam int NUM_GRIDS_DEF = 2;
   localparam int MAX_DIMS_DEF  = 64;

   // Result slots on the output channel
   localparam int CELL_SLOTS = 8;

   // Field and datapath widths
   localparam int COEFF_W    = 17;   // unsigned Q1.16
   localparam int CENTER_W   = 32;   // signed Q16.16
   localparam int COORD_W    = 32;   // signed Q16.16
   localparam int ICW_W      = 32;   // unsigned Q16.16
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 49;   // coord * coeff, exact Q.32
   localparam int ACC_W      = 56;   // wrapping accumulator, Q.32
   localparam int DIFF_W     = 57;   // accumulator minus shifted center
   localparam int MAG_W      = 56;   // magnitude of the difference
   localparam int SPLIT_W    = 32;   // low half of the magnitude
   localparam int HI_W       = MAG_W - SPLIT_W + ICW_W;   // 56
   localparam int LO_W       = SPLIT_W + ICW_W;           // 64
   localparam int SUM_W      = HI_W + 1;
   localparam int QFULL_W    = SUM_W - FRAC_W;
   localparam int Q_W        = 17;   // clamped quotient
   localparam int CELL_W     = 16;
   localparam int CELL_EXT_W = Q_W + 1;
   localparam int GRID_IDX_W = 2;    // covers up to four grids

   // Constants of the quantizer
   localparam logic [ICW_W-1:0]             ICW_RESET = 32'h0001_0000;
   localparam logic [Q_W-1:0]               Q_CLAMP   = 17'd70000;
   localparam logic signed [CELL_EXT_W-1:0] CELL_ONE  = 18'sd1;
   localparam logic signed [CELL_EXT_W-1:0] CELL_HI   = 18'sd32767;
   localparam logic signed [CELL_EXT_W-1:0] CELL_LO   = -18'sd32768;
   localparam logic [CELL_W-1:0]            CELL_SAT_HI = 16'h7fff;
   localparam logic [CELL_W-1:0]            CELL_SAT_LO = 16'h8000;

   // Request kinds on the input channel
   localparam logic [1:0] REQ_LOAD_COEFF  = 2'd0;
   localparam logic [1:0] REQ_LOAD_CENTER = 2'd1;
   localparam logic [1:0] REQ_COORD       = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMIT,
      ST_FLUSH
   } ctrl_state_type;

   // One grid pass handed from the sequencer to the cell pipeline
   typedef struct packed {
      logic                  valid;
      logic [GRID_IDX_W-1:0] grid;
      logic                  last;
   } issue_type;

   // Cell pipeline status back to the sequencer and the MAC
   typedef struct packed {
      logic adv;
      logic acc_release;
      logic last_loaded;
   } emit_status_type;

   // Tag that travels with a result through the cell pipeline
   typedef struct packed {
      logic grid;
      logic last;
   } rsp_tag_type;

endpackage

// ===== rtl/core/lpgq_coeff_mac.sv =====
// Coefficient memory and the per-projection multiply-accumulate lanes.
// Depends on lpgq_pkg.
`timescale 1ns / 1ps

module lpgq_coeff_mac #(
   parameter int NUM_PROJ = lpgq_pkg::NUM_PROJ_DEF,
   parameter int MAX_DIMS = lpgq_pkg::MAX_DIMS_DEF,
   localparam int ROW_W = (NUM_PROJ > 1) ? $clog2(NUM_PROJ) : 1,
   localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         coord_take,
   input  logic [lpgq_pkg::COORD_W-1:0]                 coord_value,
   input  logic                                         coeff_we,
   input  logic [ROW_W-1:0]                             coeff_row,
   input  logic [DIM_W-1:0]                             coeff_dim,
   input  logic [lpgq_pkg::COEFF_W-1:0]                 coeff_value,
   input  logic                                         acc_clear,
   output logic [NUM_PROJ-1:0][lpgq_pkg::ACC_W-1:0]     acc,
   output logic                                         busy
);
   import lpgq_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIMS + 1);

   // One row per dimension, one lane per projection
   logic [NUM_PROJ-1:0][COEFF_W-1:0] coeff_mem [MAX_DIMS];
   logic [NUM_PROJ-1:0][COEFF_W-1:0] coeff_rd_ff;
   logic [COORD_W-1:0]               coord_ff;

   logic [CNT_W-1:0] dim_count_ff, dim_count_in;
   logic             a_valid_ff, a_valid_in;
   logic             m_valid_ff, m_valid_in;
   logic             mac_en;

   logic [NUM_PROJ-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_PROJ-1:0][ACC_W-1:0]  acc_ff, acc_in;

   // Coordinates past the last dimension are dropped
   assign mac_en = coord_take && (dim_count_ff < CNT_W'(MAX_DIMS));

   // Coefficient loads write one lane of a row
   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[coeff_dim][coeff_row] <= coeff_value;
      end
   end

   // Row read for the current dimension, registered with the coordinate
   always_ff @(posedge clock) begin
      if (mac_en) begin
         coeff_rd_ff <= coeff_mem[dim_count_ff[DIM_W-1:0]];
         coord_ff    <= coord_value;
      end
   end

   // Per-lane product and accumulate
   for (genvar p = 0; p < NUM_PROJ; p++) begin : g_lane
      logic signed [COORD_W+COEFF_W:0] full_prod;

      always_comb begin
         full_prod  = $signed(coord_ff) * $signed({1'b0, coeff_rd_ff[p]});
         prod_in[p] = full_prod[PROD_W-1:0];
      end

      always_comb begin
         if (acc_clear) begin
            acc_in[p] = '0;
         end else if (m_valid_ff) begin
            acc_in[p] = acc_ff[p]
                      + {{(ACC_W-PROD_W){prod_ff[p][PROD_W-1]}}, prod_ff[p]};
         end else begin
            acc_in[p] = acc_ff[p];
         end
      end
   end

   // Product register
   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   // Stage valids and dimension count
   always_comb begin
      a_valid_in = mac_en;
      m_valid_in = a_valid_ff;
      if (acc_clear) begin
         dim_count_in = '0;
      end else if (mac_en) begin
         dim_count_in = dim_count_ff + CNT_W'(1);
      end else begin
         dim_count_in = dim_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         dim_count_ff <= '0;
         acc_ff       <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         m_valid_ff   <= m_valid_in;
         dim_count_ff <= dim_count_in;
         acc_ff       <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign busy = a_valid_ff | m_valid_ff;

`ifndef SYNTHESIS
   // Accumulators are only released once the MAC pipe has drained
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      acc_clear |-> !a_valid_ff && !m_valid_ff)
      else $error("accumulator cleared while MAC pipe busy");
`endif

endmodule

// ===== rtl/core/lpgq_cell_pipe.sv =====
// Center memory, cell quantizer pipeline and the result register.
// Depends on lpgq_pkg.
`timescale 1ns / 1ps

module lpgq_cell_pipe #(
   parameter int NUM_PROJ  = lpgq_pkg::NUM_PROJ_DEF,
   parameter int NUM_GRIDS = lpgq_pkg::NUM_GRIDS_DEF,
   localparam int ROW_W  = (NUM_PROJ > 1) ? $clog2(NUM_PROJ) : 1,
   localparam int GRID_W = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  lpgq_pkg::issue_type                       issue,
   input  logic [NUM_PROJ-1:0][lpgq_pkg::ACC_W-1:0]  acc,
   input  logic [lpgq_pkg::ICW_W-1:0]                inv_cell_width,
   input  logic                                      center_we,
   input  logic [GRID_W-1:0]                         center_grid,
   input  logic [ROW_W-1:0]                          center_row,
   input  logic [lpgq_pkg::CENTER_W-1:0]             center_value,
   input  logic                                      rsp_stall,
   output logic                                      rsp_valid,
   output logic [NUM_PROJ-1:0][lpgq_pkg::CELL_W-1:0] rsp_cells,
   output logic                                      rsp_grid_id,
   output logic                                      rsp_last_result,
   output lpgq_pkg::emit_status_type                 status
);
   import lpgq_pkg::*;

   localparam int CSX_W = DIFF_W - CENTER_W - FRAC_W;

   // One row per grid, one lane per projection
   logic [NUM_PROJ-1:0][CENTER_W-1:0] center_mem [NUM_GRIDS];
   logic [NUM_PROJ-1:0][CENTER_W-1:0] center_rd_ff;

   logic adv;
   logic issue_take;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, rsp_valid_in;
   rsp_tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, rsp_tag_ff;

   // Whole pipeline moves unless a result waits on a stalled receiver
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign issue_take = issue.valid && adv;

   // Center loads
   always_ff @(posedge clock) begin
      if (center_we) begin
         center_mem[center_grid][center_row] <= center_value;
      end
   end

   // Center row read for the grid being issued
   always_ff @(posedge clock) begin
      if (issue_take) begin
         center_rd_ff <= center_mem[issue.grid[GRID_W-1:0]];
      end
   end

   // Tags follow the data
   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff    <= '{grid: issue.grid[0], last: issue.last};
         tag2_ff    <= tag1_ff;
         tag3_ff    <= tag2_ff;
         tag4_ff    <= tag3_ff;
         tag5_ff    <= tag4_ff;
         rsp_tag_ff <= tag5_ff;
      end
   end

   // Stage valids
   always_comb begin
      if (adv) begin
         v1_in        = issue.valid;
         v2_in        = v1_ff;
         v3_in        = v2_ff;
         v4_in        = v3_ff;
         v5_in        = v4_ff;
         rsp_valid_in = v5_ff;
      end else begin
         v1_in        = v1_ff;
         v2_in        = v2_ff;
         v3_in        = v3_ff;
         v4_in        = v4_ff;
         v5_in        = v5_ff;
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         v5_ff        <= v5_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Per-projection quantizer lanes
   for (genvar p = 0; p < NUM_PROJ; p++) begin : g_lane
      logic [DIFF_W-1:0]            diff_ff, diff_in, mag_full;
      logic [MAG_W-1:0]             mag_ff;
      logic                         neg3_ff, neg4_ff, neg5_ff;
      logic [HI_W-1:0]              hi_ff, hi_in;
      logic [LO_W-1:0]              lo_full;
      logic [SPLIT_W-1:0]           lohi_ff;
      logic [SUM_W-1:0]             sum;
      logic [QFULL_W-1:0]           q_full;
      logic [Q_W-1:0]               q_ff, q_in;
      logic signed [CELL_EXT_W-1:0] q_ext, r_val;
      logic [CELL_W-1:0]            cell_ff, cell_in;

      // Stage 2: accumulator minus the center shifted to Q.32
      assign diff_in = {acc[p][ACC_W-1], acc[p]}
                     - {{CSX_W{center_rd_ff[p][CENTER_W-1]}}, center_rd_ff[p],
                        {FRAC_W{1'b0}}};

      // Stage 3: sign and magnitude
      assign mag_full = diff_ff[DIFF_W-1] ? (DIFF_W'(0) - diff_ff) : diff_ff;

      // Stage 4: split multiply by the reciprocal width
      always_comb begin
         hi_in   = mag_ff[MAG_W-1:SPLIT_W] * inv_cell_width;
         lo_full = mag_ff[SPLIT_W-1:0] * inv_cell_width;
      end

      // Stage 5: recombine, drop the fraction, clamp
      always_comb begin
         sum    = {1'b0, hi_ff} + {{(SUM_W-SPLIT_W){1'b0}}, lohi_ff};
         q_full = sum[SUM_W-1:FRAC_W];
         q_in   = (q_full > QFULL_W'(Q_CLAMP)) ? Q_CLAMP : q_full[Q_W-1:0];
      end

      // Output: restore the sign, add one, saturate to 16 bits
      always_comb begin
         q_ext = $signed({1'b0, q_ff});
         r_val = neg5_ff ? (CELL_ONE - q_ext) : (q_ext + CELL_ONE);
         if (r_val > CELL_HI) begin
            cell_in = CELL_SAT_HI;
         end else if (r_val < CELL_LO) begin
            cell_in = CELL_SAT_LO;
         end else begin
            cell_in = r_val[CELL_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            diff_ff <= diff_in;
            neg3_ff <= diff_ff[DIFF_W-1];
            mag_ff  <= mag_full[MAG_W-1:0];
            neg4_ff <= neg3_ff;
            hi_ff   <= hi_in;
            lohi_ff <= lo_full[LO_W-1:SPLIT_W];
            neg5_ff <= neg4_ff;
            q_ff    <= q_in;
            cell_ff <= cell_in;
         end
      end

      assign rsp_cells[p] = cell_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grid_id     = rsp_tag_ff.grid;
   assign rsp_last_result = rsp_tag_ff.last;

   // Last grid reads the accumulators as it leaves stage 1
   assign status.adv         = adv;
   assign status.acc_release = adv && v1_ff && tag1_ff.last;
   assign status.last_loaded = adv && v5_ff && tag5_ff.last;

`ifndef SYNTHESIS
   // Never more grid passes in flight than one point produces
   a_inflight: assert property (@(posedge clock) disable iff (reset)
      $countones({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff}) <= NUM_GRIDS)
      else $error("too many grid passes in flight");

   // The closing result always belongs to the highest grid
   a_last_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tag_ff.last |-> rsp_tag_ff.grid == 1'(NUM_GRIDS - 1))
      else $error("last result carries wrong grid");
`endif

endmodule

// ===== rtl/core/lpgq_ctrl.sv =====
// Sequencer: input throttling, drain wait and grid pass issue.
// Depends on lpgq_pkg.
`timescale 1ns / 1ps

module lpgq_ctrl #(
   parameter int NUM_GRIDS = lpgq_pkg::NUM_GRIDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      coord_last_take,
   input  logic                      mac_busy,
   input  lpgq_pkg::emit_status_type status,
   output logic                      req_stall,
   output lpgq_pkg::issue_type       issue
);
   import lpgq_pkg::*;

   localparam int GRID_W = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;

   ctrl_state_type    state_ff, state_in;
   logic [GRID_W-1:0] grid_ff, grid_in;
   logic              grid_last;

   assign grid_last = (grid_ff == GRID_W'(NUM_GRIDS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (coord_last_take) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.adv && grid_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.last_loaded) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Grid counter steps with each accepted pass
   always_comb begin
      grid_in = grid_ff;
      if (state_ff == ST_EMIT && status.adv) begin
         grid_in = grid_last ? '0 : grid_ff + GRID_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         grid_ff  <= '0;
      end else begin
         state_ff <= state_in;
         grid_ff  <= grid_in;
      end
   end

   // Outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      issue.valid = (state_ff == ST_EMIT);
      issue.grid  = GRID_IDX_W'(grid_ff);
      issue.last  = grid_last;
   end

`ifndef SYNTHESIS
   // Grid passes start only on final accumulator values
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !mac_busy)
      else $error("grid pass issued while MAC busy");

   // Counter rests at zero outside of issue
   a_grid_rest: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_EMIT |-> grid_ff == '0)
      else $error("grid counter not at rest");

   // The closing result only appears once all passes are issued
   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      status.last_loaded |-> state_ff == ST_FLUSH)
      else $error("last result outside flush");
`endif

endmodule

// ===== rtl/core/lsh_projection_grid_quantizer_core.sv =====
// Random-projection grid quantizer: top level. Uses lpgq_pkg, lpgq_coeff_mac,
// lpgq_cell_pipe and lpgq_ctrl.
//
// Input channel (req_*, valid/stall): req_type selects a coefficient load, a center
// load or a point coordinate. Loads and coordinates are taken one per cycle while
// the block is idle. A coordinate reads one coefficient row from memory and goes
// through a two-stage multiply-accumulate on NUM_PROJ lanes.
// On a coordinate with req_last_coord set the input stalls. Once the MAC pipe
// drains, one pass per grid enters a five-stage cell pipeline that reads the
// center memory; the items show on rsp_* one per cycle while rsp_stall is low,
// grid 0 first, the final one with rsp_last_result set. Input resumes in the
// same cycle as the final item reaches the output register. rsp_stall, while
// an item is held, freezes the whole cell pipeline; the held item does not change.
// csr_wr_en writes inv_cell_width (unsigned Q16.16), idle only; the user must
// keep to this, as the block does not enforce it.
// Reset (synchronous) sets inv_cell_width to 1.0 and clears accumulators, the
// dimension count and all valids; coefficient and center memories are not
// cleared and must be loaded before use.
`timescale 1ns / 1ps

module lsh_projection_grid_quantizer_core #(
   parameter int NUM_PROJ  = lpgq_pkg::NUM_PROJ_DEF,
   parameter int NUM_GRIDS = lpgq_pkg::NUM_GRIDS_DEF,
   parameter int MAX_DIMS  = lpgq_pkg::MAX_DIMS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [lpgq_pkg::ICW_W-1:0]     csr_wr_data,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [2:0]                     req_proj_index,
   input  logic [5:0]                     req_dim_index,
   input  logic                           req_offset_sel,
   input  logic [lpgq_pkg::COEFF_W-1:0]   req_coeff_value,
   input  logic [lpgq_pkg::CENTER_W-1:0]  req_center_value,
   input  logic [lpgq_pkg::COORD_W-1:0]   req_coord_value,
   input  logic                           req_last_coord,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_0,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_1,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_2,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_3,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_4,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_5,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_6,
   output logic [lpgq_pkg::CELL_W-1:0]    rsp_cell_7,
   output logic                           rsp_grid_id,
   output logic                           rsp_last_result
);
   import lpgq_pkg::*;

   localparam int ROW_W  = (NUM_PROJ > 1) ? $clog2(NUM_PROJ) : 1;
   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int GRID_W = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;

   logic [ICW_W-1:0] inv_cell_width_ff, inv_cell_width_in;

   logic req_take, coord_take, coord_last_take;
   logic coeff_we, center_we;
   logic mac_busy;

   logic [NUM_PROJ-1:0][ACC_W-1:0]    acc;
   logic [NUM_PROJ-1:0][CELL_W-1:0]   rsp_cells;
   logic [CELL_SLOTS-1:0][CELL_W-1:0] cell_bus;

   issue_type       issue;
   emit_status_type status;

   // Configuration register
   assign inv_cell_width_in = csr_wr_en ? csr_wr_data : inv_cell_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_cell_width_ff <= ICW_RESET;
      end else begin
         inv_cell_width_ff <= inv_cell_width_in;
      end
   end

   // Request decode; out-of-range loads are dropped
   always_comb begin
      req_take        = req_valid && !req_stall;
      coord_take      = req_take && (req_type == REQ_COORD);
      coord_last_take = coord_take && req_last_coord;
      coeff_we        = req_take && (req_type == REQ_LOAD_COEFF)
                     && (32'(req_proj_index) < NUM_PROJ)
                     && (32'(req_dim_index) < MAX_DIMS);
      center_we       = req_take && (req_type == REQ_LOAD_CENTER)
                     && (32'(req_proj_index) < NUM_PROJ)
                     && (32'(req_offset_sel) < NUM_GRIDS);
   end

   lpgq_coeff_mac #(
      .NUM_PROJ (NUM_PROJ),
      .MAX_DIMS (MAX_DIMS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .coord_take  (coord_take),
      .coord_value (req_coord_value),
      .coeff_we    (coeff_we),
      .coeff_row   (ROW_W'(req_proj_index)),
      .coeff_dim   (DIM_W'(req_dim_index)),
      .coeff_value (req_coeff_value),
      .acc_clear   (status.acc_release),
      .acc         (acc),
      .busy        (mac_busy)
   );

   lpgq_cell_pipe #(
      .NUM_PROJ  (NUM_PROJ),
      .NUM_GRIDS (NUM_GRIDS)
   ) u_cells (
      .clock           (clock),
      .reset           (reset),
      .issue           (issue),
      .acc             (acc),
      .inv_cell_width  (inv_cell_width_ff),
      .center_we       (center_we),
      .center_grid     (GRID_W'(req_offset_sel)),
      .center_row      (ROW_W'(req_proj_index)),
      .center_value    (req_center_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_cells       (rsp_cells),
      .rsp_grid_id     (rsp_grid_id),
      .rsp_last_result (rsp_last_result),
      .status          (status)
   );

   lpgq_ctrl #(
      .NUM_GRIDS (NUM_GRIDS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .coord_last_take (coord_last_take),
      .mac_busy        (mac_busy),
      .status          (status),
      .req_stall       (req_stall),
      .issue           (issue)
   );

   // Unused projection slots read as zero
   for (genvar j = 0; j < CELL_SLOTS; j++) begin : g_slot
      if (j < NUM_PROJ) begin : g_used
         assign cell_bus[j] = rsp_cells[j];
      end else begin : g_unused
         assign cell_bus[j] = '0;
      end
   end

   assign rsp_cell_0 = cell_bus[0];
   assign rsp_cell_1 = cell_bus[1];
   assign rsp_cell_2 = cell_bus[2];
   assign rsp_cell_3 = cell_bus[3];
   assign rsp_cell_4 = cell_bus[4];
   assign rsp_cell_5 = cell_bus[5];
   assign rsp_cell_6 = cell_bus[6];
   assign rsp_cell_7 = cell_bus[7];

endmodule
